// ===== src/grcd_pkg.sv =====
// ----------------------------------------------------------------------------
// grcd_pkg
// Types, constants and row-step logic shared by the ring automaton direction
// block.
// ----------------------------------------------------------------------------
package grcd_pkg;

    localparam int ROW_W      = 8;
    localparam int RULE_WORDS = 8;
    localparam int WORD_W     = 64;
    localparam int RULE_BITS  = RULE_WORDS * WORD_W;
    localparam int CFG_IDX_W  = 4;
    localparam int DIR_W      = 3;
    localparam int OFF_W      = 2;

    typedef struct packed {
        logic [ROW_W-1:0] oldest_row;
        logic [ROW_W-1:0] middle_row;
        logic [ROW_W-1:0] newest_row;
    } t_in_req;

    typedef struct packed {
        logic [DIR_W-1:0] direction_index;
        logic [OFF_W-1:0] offset_x;
        logic [OFF_W-1:0] offset_y;
    } t_out_req;

    // One automaton generation: 8 independent 512:1 rule lookups.
    function automatic logic [ROW_W-1:0] next_row(
        input logic [RULE_BITS-1:0] rule,
        input logic [ROW_W-1:0]     r3,
        input logic [ROW_W-1:0]     r2,
        input logic [ROW_W-1:0]     r1
    );
        logic [ROW_W-1:0] res;
        logic [2:0]       l;
        logic [2:0]       c;
        logic [2:0]       r;
        logic [8:0]       addr;
        res = '0;
        for (int x = 0; x < ROW_W; x++) begin
            c    = 3'(x);
            l    = c - 3'd1;
            r    = c + 3'd1;
            addr = {r3[r], r3[c], r3[l], r2[r], r2[c], r2[l], r1[r], r1[c], r1[l]};
            res[x] = rule[addr];
        end
        return res;
    endfunction

    // Clockwise from the top-left corner.
    function automatic logic [OFF_W-1:0] dir_off_x(input logic [DIR_W-1:0] d);
        logic [OFF_W-1:0] v;
        case (d)
            3'd0:    v = 2'd0;
            3'd1:    v = 2'd1;
            3'd2:    v = 2'd2;
            3'd3:    v = 2'd2;
            3'd4:    v = 2'd2;
            3'd5:    v = 2'd1;
            3'd6:    v = 2'd0;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic logic [OFF_W-1:0] dir_off_y(input logic [DIR_W-1:0] d);
        logic [OFF_W-1:0] v;
        case (d)
            3'd0:    v = 2'd0;
            3'd1:    v = 2'd0;
            3'd2:    v = 2'd0;
            3'd3:    v = 2'd1;
            3'd4:    v = 2'd2;
            3'd5:    v = 2'd2;
            3'd6:    v = 2'd2;
            default: v = 2'd1;
        endcase
        return v;
    endfunction

endpackage

// ===== src/genome_rule_ca_direction_top.sv =====
// ----------------------------------------------------------------------------
// genome_rule_ca_direction_top
// Ring cellular automaton run from three seed rows, reduced to a move
// direction and its offset in a 3 by 3 neighborhood.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) takes three seed rows.
//   Output channel (o_out_valid / i_out_stall / o_out_req) returns one
//   direction request per input request, in order.
//   Rule table: eight 64-bit words written via i_cfg_we / i_cfg_idx /
//   i_cfg_data; indexes beyond 7 are ignored. Write only while idle.
// Timing:
//   One register stage per generated row (ROWS-3 stages), plus an input
//   and an output register; one request per cycle while not stalled.
//   Each row stage is eight 512:1 rule lookups.
// Reset:
//   i_rst_n low clears all valid bits and the rule table to zero.
// Stall:
//   i_out_stall with a result waiting freezes the whole pipeline and is
//   reflected on o_in_stall in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module genome_rule_ca_direction_top #(
    parameter int ROWS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  grcd_pkg::t_in_req                 i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output grcd_pkg::t_out_req                o_out_req,
    input  logic                              i_cfg_we,
    input  logic [grcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [grcd_pkg::WORD_W-1:0]       i_cfg_data
);
    import grcd_pkg::*;

    localparam int NS = ROWS - 3;

    logic [WORD_W-1:0]    r_rule [RULE_WORDS];
    logic [RULE_BITS-1:0] w_rule;

    logic                 r_vld  [NS+1];
    logic [ROW_W-1:0]     r_row3 [NS+1];
    logic [ROW_W-1:0]     r_row2 [NS+1];
    logic [ROW_W-1:0]     r_row1 [NS+1];

    logic                 r_out_valid;
    t_out_req             r_out_req;
    t_out_req             n_out_req;
    logic [DIR_W-1:0]     w_dir;
    logic                 w_en;

    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // rule table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RULE_WORDS; i++) begin
                r_rule[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(RULE_WORDS))) begin
            r_rule[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < RULE_WORDS; i++) begin
            w_rule[i*WORD_W +: WORD_W] = r_rule[i];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_row3[0] <= i_in_req.oldest_row;
            r_row2[0] <= i_in_req.middle_row;
            r_row1[0] <= i_in_req.newest_row;
        end
    end

    // one generation per stage
    for (genvar s = 1; s <= NS; s++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_row3[s] <= r_row2[s-1];
                r_row2[s] <= r_row1[s-1];
                r_row1[s] <= next_row(w_rule, r_row3[s-1], r_row2[s-1], r_row1[s-1]);
            end
        end
    end

    // output register
    assign w_dir = {r_row1[NS][0], r_row1[NS][1], r_row1[NS][2]};

    always_comb begin
        n_out_req.direction_index = w_dir;
        n_out_req.offset_x        = dir_off_x(w_dir);
        n_out_req.offset_y        = dir_off_y(w_dir);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_req <= n_out_req;
        end
    end

    // checks
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[NS]) |=> o_out_valid)
        else $error("last row stage did not reach the output register");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vld[0]) && $stable(r_vld[NS])))
        else $error("pipeline moved while frozen");

    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.offset_x != 2'd3 && o_out_req.offset_y != 2'd3))
        else $error("offset out of range");

    a_no_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_req.offset_x == 2'd1 && o_out_req.offset_y == 2'd1))
        else $error("direction maps to the center cell");

endmodule

// ===== tb/tb_genome_rule_ca_direction_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_genome_rule_ca_direction_top
// Self-checking bench for the ring automaton direction block. Seed-row
// requests go in through a queue-fed driver and every returned direction is
// checked in order against a local model of the automaton. The model uses
// the rule table that the bench has programmed. Rule tables cover all-zero,
// all-one, single-neighbor copy rules and random sparse, dense and uniform
// tables. Both handshake sides idle at random, and there is one long output
// hold that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_genome_rule_ca_direction_top;
    import grcd_pkg::*;

    localparam int ROWS           = 32;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 138;
    localparam int HOLD_CYCLES    = 120;
    localparam int QUIET_LIMIT    = 5000;
    localparam int MAX_REPORTS    = 10;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_req              i_in_req   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_req             o_out_req;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    logic [RULE_BITS-1:0] rule_table = '0;
    logic [WORD_W-1:0]    rule_plan [RULE_WORDS];
    t_in_req              pending_seeds [$];
    t_out_req             expected_dirs [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   holds_asked   = 0;
    int   holds_served  = 0;
    int   hold_left     = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    logic in_fired      = 1'b0;

    genome_rule_ca_direction_top #(
        .ROWS (ROWS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    // clockwise from the top-left corner, {x, y}
    function automatic logic [3:0] offset_of_direction(input logic [2:0] dir);
        case (dir)
            3'd0:    return {2'd0, 2'd0};
            3'd1:    return {2'd1, 2'd0};
            3'd2:    return {2'd2, 2'd0};
            3'd3:    return {2'd2, 2'd1};
            3'd4:    return {2'd2, 2'd2};
            3'd5:    return {2'd1, 2'd2};
            3'd6:    return {2'd0, 2'd2};
            default: return {2'd0, 2'd1};
        endcase
    endfunction

    function automatic t_out_req predict_direction(input t_in_req seeds);
        logic [ROW_W-1:0] oldest;
        logic [ROW_W-1:0] middle;
        logic [ROW_W-1:0] newest;
        logic [ROW_W-1:0] grown;
        logic [3:0]       offs;
        int               addr;
        int               lf;
        int               rt;
        t_out_req         res;
        oldest = seeds.oldest_row;
        middle = seeds.middle_row;
        newest = seeds.newest_row;
        for (int gen = 3; gen < ROWS; gen++) begin
            for (int x = 0; x < ROW_W; x++) begin
                lf   = (x + ROW_W - 1) % ROW_W;
                rt   = (x + 1) % ROW_W;
                addr = newest[lf] + 2 * newest[x] + 4 * newest[rt]
                     + 8 * middle[lf] + 16 * middle[x] + 32 * middle[rt]
                     + 64 * oldest[lf] + 128 * oldest[x] + 256 * oldest[rt];
                grown[x] = rule_table[addr];
            end
            oldest = middle;
            middle = newest;
            newest = grown;
        end
        res.direction_index = {newest[0], newest[1], newest[2]};
        offs                = offset_of_direction(res.direction_index);
        res.offset_x        = offs[3:2];
        res.offset_y        = offs[1:0];
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return ROW_W'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] random_rule_word(input int kind);
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        if (kind == 1)
            w = w & {$urandom, $urandom};
        else if (kind == 2)
            w = w | {$urandom, $urandom};
        return w;
    endfunction

    task automatic queue_seeds(input logic [ROW_W-1:0] o, input logic [ROW_W-1:0] m,
                               input logic [ROW_W-1:0] n);
        t_in_req s;
        s.oldest_row = o;
        s.middle_row = m;
        s.newest_row = n;
        pending_seeds.push_back(s);
    endtask

    task automatic wait_idle();
        while (pending_seeds.size() != 0 || i_in_valid || expected_dirs.size() != 0)
            @(posedge i_clk);
    endtask

    // writes all rule words from rule_plan, then junk_writes out-of-range writes
    task automatic program_rules(input int junk_writes);
        for (int k = 0; k < RULE_WORDS; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= rule_plan[k];
            rule_table[k*WORD_W +: WORD_W] = rule_plan[k];
        end
        for (int k = 0; k < junk_writes; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(RULE_WORDS + (k % RULE_WORDS));
            i_cfg_data <= {$urandom, $urandom};
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fired) begin
            if (pending_seeds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_req   <= pending_seeds.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            i_out_stall  <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // accepted requests
    always @(posedge i_clk) begin
        in_fired <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_dirs.push_back(predict_direction(i_in_req));
    end

    // returned directions
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_dirs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: unexpected direction %0d offset (%0d,%0d)",
                             o_out_req.direction_index, o_out_req.offset_x,
                             o_out_req.offset_y);
            end else begin
                want = expected_dirs.pop_front();
                if (o_out_req.direction_index != want.direction_index ||
                    o_out_req.offset_x != want.offset_x ||
                    o_out_req.offset_y != want.offset_y) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: dir exp %0d got %0d, x exp %0d got %0d, y exp %0d got %0d",
                                 want.direction_index, o_out_req.direction_index,
                                 want.offset_x, o_out_req.offset_x,
                                 want.offset_y, o_out_req.offset_y);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [2:0] d;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset table is all zero
        set_idling(30, 67);
        queue_seeds(8'h00, 8'h00, 8'h00);
        queue_seeds(8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // new cell copies its own cell of the previous row: last seed survives
        for (int k = 0; k < RULE_WORDS; k++)
            rule_plan[k] = 64'hCCCC_CCCC_CCCC_CCCC;
        program_rules(0);
        for (int k = 0; k < 8; k++) begin
            d = 3'(k);
            queue_seeds((k % 2) ? 8'hFF : 8'h00, (k % 4 < 2) ? 8'h80 : 8'h01,
                        {5'(k * 7), d[0], d[1], d[2]});
        end
        wait_idle();

        // all ones, plus writes to every index past the table
        for (int k = 0; k < RULE_WORDS; k++)
            rule_plan[k] = '1;
        program_rules(RULE_WORDS);
        queue_seeds(8'h00, 8'h00, 8'h00);
        queue_seeds(8'h5A, 8'hA5, 8'h3C);
        queue_seeds(8'hFF, 8'h00, 8'h00);
        wait_idle();

        // copy own cell three rows back
        for (int k = 0; k < RULE_WORDS; k++)
            rule_plan[k] = (k % 4 >= 2) ? '1 : '0;
        program_rules(1);
        queue_seeds(8'h07, 8'h00, 8'hF8);
        queue_seeds(8'h00, 8'h05, 8'h00);
        queue_seeds(8'h00, 8'h00, 8'h03);
        wait_idle();

        // copy left neighbor of the previous row: ring rotation
        for (int k = 0; k < RULE_WORDS; k++)
            rule_plan[k] = 64'hAAAA_AAAA_AAAA_AAAA;
        program_rules(1);
        queue_seeds(8'h00, 8'h00, 8'h01);
        queue_seeds(8'h00, 8'h00, 8'h80);
        queue_seeds(8'h00, 8'h00, 8'h10);
        queue_seeds(8'hFF, 8'hFF, 8'h48);
        wait_idle();

        // copy right neighbor three rows back
        for (int k = 0; k < RULE_WORDS; k++)
            rule_plan[k] = (k >= RULE_WORDS / 2) ? '1 : '0;
        program_rules(1);
        queue_seeds(8'h01, 8'h00, 8'h00);
        queue_seeds(8'h80, 8'h40, 8'h20);
        queue_seeds(8'hC3, 8'h00, 8'hFF);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 2)
                set_idling(30, 67);
            else if (p < 4)
                set_idling(67, 30);
            else
                set_idling(0, 0);
            for (int k = 0; k < RULE_WORDS; k++)
                rule_plan[k] = random_rule_word(p % 3);
            program_rules($urandom_range(2));
            for (int k = 0; k < RAND_PER_PHASE; k++)
                queue_seeds(pick_row(), pick_row(), pick_row());
            if (p == 0) begin
                while (pending_seeds.size() > RAND_PER_PHASE / 2)
                    @(negedge i_clk);
                holds_asked = holds_asked + 1;
            end
            wait_idle();
        end

        repeat (ROWS + 8) @(negedge i_clk);
        if (mismatches == 0 && expected_dirs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/grcd_pkg.sv
src/genome_rule_ca_direction_top.sv
tb/tb_genome_rule_ca_direction_top.sv
